// ===== hdl/rotdec_pkg.sv =====
// Shared types and constants for the rotary encoder decoder.
// Holds the detent state encoding, the rotation event codes and register indexes.
// No dependencies.
package rotdec_pkg;

  // Configuration register fields.
  localparam int unsigned DEB_W       = 20;
  localparam int unsigned CFG_DATA_W  = 32;
  localparam int unsigned CFG_ADDR_W  = 3;

  localparam logic [DEB_W-1:0] BUTTON_DEB_RESET = 20'd20000;
  localparam logic [DEB_W-1:0] ROTATE_DEB_RESET = 20'd1000;

  // Default timestamp width in use.
  localparam int unsigned TIME_BITS_DEFAULT = 64;

  // Register index taken from the word address.
  typedef enum logic {
    REG_BUTTON_DEB = 1'b0,
    REG_ROTATE_DEB = 1'b1
  } reg_index_t;

  // Detent machine states.
  typedef enum logic [2:0] {
    DET_IDLE       = 3'd0,
    DET_FIRST_CW   = 3'd1,
    DET_FIRST_CCW  = 3'd2,
    DET_SECOND_CW  = 3'd3,
    DET_SECOND_CCW = 3'd4,
    DET_CW         = 3'd5,
    DET_CCW        = 3'd6
  } det_state_t;

  // Rotation event codes on the result channel.
  typedef enum logic [1:0] {
    EV_NONE = 2'd0,
    EV_CW   = 2'd1,
    EV_CCW  = 2'd2
  } rot_event_t;

endpackage

// ===== hdl/rotary_encoder_debounced_decoder_top.sv =====
// Top level of the debounced rotary encoder and push-button decoder.
// Depends on rotdec_pkg for the detent states, event codes and register indexes.
//
// Usage:
// The input channel (in_valid, in_stall) carries one poll sample per transfer:
// the button, A and B pin levels (active low) and a microsecond timestamp.
// The result channel (out_valid, out_stall) carries one result per sample:
// a debounced button press flag and a rotation event (none, CW or CCW).
// Two debounce times are set through the APB-style port: button debounce at
// byte address 0 and rotate debounce at byte address 4, both 20 bits wide.
// Write them only while no sample is in flight.
// A sample lands in the input register; when the result register can take it,
// the debounce subtract and compare and the detent machine update the state
// and fill the result register, and out_valid rises as that register fills.
// Throughput is one sample per cycle while the receiver does not stall.
// When the receiver stalls, the result register holds; the input register
// still takes one more sample, and then in_stall rises until the result moves.
// Reset loads the default debounce times, clears both recorded times, puts the
// detent machine in idle and the latched A/B levels at high, and empties both
// registers.
module rotary_encoder_debounced_decoder_top
  import rotdec_pkg::*;
#(
  parameter int unsigned TIME_BITS = TIME_BITS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Input channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_button_level,
  input  logic                  in_a_level,
  input  logic                  in_b_level,
  input  logic [63:0]           in_now_time,
  // Result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_button_pressed,
  output logic [1:0]            out_rotate_event,
  // Configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  // Width used to compare a time difference with a debounce time.
  localparam int unsigned CMP_W = (TIME_BITS > DEB_W) ? TIME_BITS : DEB_W;

  // Configuration registers.
  logic [DEB_W-1:0] button_deb_r;
  logic [DEB_W-1:0] rotate_deb_r;
  reg_index_t       cfg_index;
  logic             cfg_write;

  // Input register.
  logic                 s1_valid_r;
  logic                 s1_btn_r;
  logic                 s1_a_r;
  logic                 s1_b_r;
  logic [TIME_BITS-1:0] s1_time_r;

  // Decoder state.
  logic [TIME_BITS-1:0] last_press_r;
  logic [TIME_BITS-1:0] last_turn_r;
  det_state_t           det_r;
  det_state_t           det_nxt;
  logic                 latched_a_r;
  logic                 latched_b_r;

  // Result register.
  logic       out_valid_r;
  logic       pressed_r;
  rot_event_t event_r;

  // Handshake and per-sample logic.
  logic             in_take;
  logic             out_ready;
  logic             s2_load;
  logic [TIME_BITS-1:0] press_diff;
  logic [TIME_BITS-1:0] turn_diff;
  logic [CMP_W-1:0] press_diff_ext;
  logic [CMP_W-1:0] turn_diff_ext;
  logic             press_take;
  logic             turn_take;
  rot_event_t       event_nxt;

  // Configuration writes and reads.
  assign pready    = 1'b1;
  assign cfg_index = reg_index_t'(paddr[2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      button_deb_r <= BUTTON_DEB_RESET;
      rotate_deb_r <= ROTATE_DEB_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_BUTTON_DEB: button_deb_r <= pwdata[DEB_W-1:0];
        REG_ROTATE_DEB: rotate_deb_r <= pwdata[DEB_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_index)
      REG_BUTTON_DEB: prdata = CFG_DATA_W'(button_deb_r);
      REG_ROTATE_DEB: prdata = CFG_DATA_W'(rotate_deb_r);
      default:        prdata = '0;
    endcase
  end

  // Flow control: the input register moves on whenever the result register
  // is empty or its transfer completes in this cycle.
  assign out_ready = !out_valid_r || !out_stall;
  assign s2_load   = s1_valid_r && out_ready;
  assign in_stall  = s1_valid_r && !out_ready;
  assign in_take   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (s2_load) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_btn_r  <= in_button_level;
      s1_a_r    <= in_a_level;
      s1_b_r    <= in_b_level;
      s1_time_r <= in_now_time[TIME_BITS-1:0];
    end
  end

  // Debounce checks: wrapping differences against the debounce times.
  assign press_diff     = s1_time_r - last_press_r;
  assign turn_diff      = s1_time_r - last_turn_r;
  assign press_diff_ext = CMP_W'(press_diff);
  assign turn_diff_ext  = CMP_W'(turn_diff);
  assign press_take     = !s1_btn_r && (press_diff_ext > CMP_W'(button_deb_r));
  assign turn_take      = ((s1_a_r != latched_a_r) || (s1_b_r != latched_b_r)) &&
                          (turn_diff_ext > CMP_W'(rotate_deb_r));

  // Detent machine next state and event for the newly latched A/B pair.
  always_comb begin
    det_nxt   = det_r;
    event_nxt = EV_NONE;
    unique case (det_r)
      DET_FIRST_CW: begin
        if (s1_a_r && s1_b_r) det_nxt = DET_IDLE;
        else if (!s1_a_r && !s1_b_r) det_nxt = DET_SECOND_CW;
      end
      DET_FIRST_CCW: begin
        if (s1_a_r && s1_b_r) det_nxt = DET_IDLE;
        else if (!s1_a_r && !s1_b_r) det_nxt = DET_SECOND_CCW;
      end
      DET_SECOND_CW: begin
        if (s1_a_r && s1_b_r) det_nxt = DET_IDLE;
        else if (!s1_b_r) det_nxt = DET_CW;
      end
      DET_SECOND_CCW: begin
        if (s1_a_r && s1_b_r) det_nxt = DET_IDLE;
        else if (!s1_a_r) det_nxt = DET_CCW;
      end
      DET_CW: begin
        if (!s1_b_r) begin
          det_nxt = DET_IDLE;
        end else if (s1_a_r) begin
          det_nxt   = DET_IDLE;
          event_nxt = EV_CW;
        end
      end
      DET_CCW: begin
        if (!s1_a_r) begin
          det_nxt = DET_IDLE;
        end else if (s1_b_r) begin
          det_nxt   = DET_IDLE;
          event_nxt = EV_CCW;
        end
      end
      default: begin
        // Idle, and the unused code, which behaves the same.
        if (!s1_a_r) det_nxt = DET_FIRST_CW;
        else if (!s1_b_r) det_nxt = DET_FIRST_CCW;
        else det_nxt = DET_IDLE;
      end
    endcase
  end

  // Detent state register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      det_r <= DET_IDLE;
    end else if (s2_load && turn_take) begin
      det_r <= det_nxt;
    end
  end

  // Recorded times and latched channel levels.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_press_r <= '0;
      last_turn_r  <= '0;
      latched_a_r  <= 1'b1;
      latched_b_r  <= 1'b1;
    end else if (s2_load) begin
      if (press_take) begin
        last_press_r <= s1_time_r;
      end
      if (turn_take) begin
        last_turn_r <= s1_time_r;
        latched_a_r <= s1_a_r;
        latched_b_r <= s1_b_r;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_ready) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      pressed_r <= press_take;
      event_r   <= turn_take ? event_nxt : EV_NONE;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_button_pressed = pressed_r;
  assign out_rotate_event   = event_r;

  // A reported step always leaves the detent machine idle.
  assert property (@(posedge clk) disable iff (!rst_n)
    (s2_load && turn_take && event_nxt != EV_NONE) |=> det_r == DET_IDLE)
    else $error("detent machine not idle after a reported step");

  // The latched A/B pair changes only through an accepted turn.
  assert property (@(posedge clk) disable iff (!rst_n)
    (!$stable(latched_a_r) || !$stable(latched_b_r)) |->
      $past(s2_load && turn_take))
    else $error("A/B latch changed without an accepted turn");

  // A reported press records the sample time.
  assert property (@(posedge clk) disable iff (!rst_n)
    (s2_load && press_take) |=> last_press_r == $past(s1_time_r))
    else $error("press time not recorded");

  // The input side stalls only with both registers full.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r && out_stall))
    else $error("input stalled without a full pipeline");

endmodule
